>>> rtl/sbce_pkg.sv
// ----------------------------------------------------------------------------
// sbce_pkg
// Shared constants and controller/datapath types for the size budget cache
// evictor.
// ----------------------------------------------------------------------------
`default_nettype none

package sbce_pkg;

    // table geometry
    localparam int SLOTS = 16;
    localparam int IW    = $clog2(SLOTS);
    localparam int LG    = $clog2(SLOTS);
    localparam int P     = 1 << LG;

    // field widths
    localparam int KEY_W    = 32;
    localparam int BYTES_W  = 36;
    localparam int PX_W     = 14;
    localparam int BUDGET_W = 40;
    localparam int EVICT_W  = 5;
    localparam int EVICT_MAX = (1 << EVICT_W) - 1;

    // prefix sum of all slots fits here
    localparam int SUMW = BYTES_W + LG + 1;
    localparam int CMPW = (SUMW > BUDGET_W) ? SUMW : BUDGET_W;

    // sequencing counter covers issue plus tree drain
    localparam int CW = $clog2(SLOTS + LG + 2);

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(512 * 1024 * 1024);

    // command codes
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_PROBE   = 1'b1;

    typedef struct packed {
        logic          load;
        logic          issue;
        logic [IW-1:0] idx;
        logic          apply;
        logic          lookup;
    } t_cmd;

    typedef struct packed {
        logic probe;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/sbce_dp.sv
// ----------------------------------------------------------------------------
// sbce_dp
// Slot table, ranked prefix-sum tree, eviction mask, lookup and insert.
// ----------------------------------------------------------------------------
`default_nettype none

module sbce_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sbce_pkg::t_cmd                 i_cmd,
    output sbce_pkg::t_sts                      o_sts,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbce_pkg::BUDGET_W-1:0]  i_cfg_data,
    input  wire logic                           i_command,
    input  wire logic [sbce_pkg::KEY_W-1:0]     i_key_tag,
    input  wire logic [sbce_pkg::BYTES_W-1:0]   i_entry_bytes,
    input  wire logic [sbce_pkg::PX_W-1:0]      i_width_px,
    input  wire logic [sbce_pkg::PX_W-1:0]      i_height_px,
    input  wire logic                           i_load_ok,
    output logic                                o_was_present,
    output logic                                o_available,
    output logic [sbce_pkg::PX_W-1:0]           o_out_width_px,
    output logic [sbce_pkg::PX_W-1:0]           o_out_height_px,
    output logic [sbce_pkg::EVICT_W-1:0]        o_evicted_count,
    output logic                                o_table_full
);

    localparam int SLOTS = sbce_pkg::SLOTS;
    localparam int IW    = sbce_pkg::IW;
    localparam int LG    = sbce_pkg::LG;
    localparam int P     = sbce_pkg::P;
    localparam int SUMW  = sbce_pkg::SUMW;
    localparam int CMPW  = sbce_pkg::CMPW;

    // budget register
    logic [sbce_pkg::BUDGET_W-1:0] r_budget;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= sbce_pkg::BUDGET_RESET;
        end else if (i_cfg_we) begin
            r_budget <= i_cfg_data;
        end
    end

    // captured item
    logic                          r_cmd;
    logic [sbce_pkg::KEY_W-1:0]    r_key;
    logic [sbce_pkg::BYTES_W-1:0]  r_bytes;
    logic [sbce_pkg::PX_W-1:0]     r_w;
    logic [sbce_pkg::PX_W-1:0]     r_h;
    logic                          r_ok;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_key   <= i_key_tag;
            r_bytes <= i_entry_bytes;
            r_w     <= i_width_px;
            r_h     <= i_height_px;
            r_ok    <= i_load_ok;
        end
    end
    assign o_sts.probe = (r_cmd == sbce_pkg::CMD_PROBE);

    // slot table
    logic [SLOTS-1:0]              r_valid;
    logic [sbce_pkg::KEY_W-1:0]    r_skey   [0:SLOTS-1];
    logic [sbce_pkg::BYTES_W-1:0]  r_sbytes [0:SLOTS-1];
    logic [sbce_pkg::PX_W-1:0]     r_sw     [0:SLOTS-1];
    logic [sbce_pkg::PX_W-1:0]     r_sh     [0:SLOTS-1];

    // eviction candidates: valid and not the requested key
    logic [SLOTS-1:0] cand;
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            cand[j] = r_valid[j] && (r_skey[j] != r_key);
        end
    end

    // rank mask against the issued slot, then registered adder tree
    logic [SUMW-1:0]              r_tree [0:LG][0:P-1];
    logic [LG:0]                  r_tv;
    logic [IW-1:0]                r_ti   [0:LG];
    logic [sbce_pkg::BYTES_W-1:0] bi;
    assign bi = r_sbytes[i_cmd.idx];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < P; j++) begin
            if (j < SLOTS) begin
                if (cand[j] && ((r_sbytes[j] < bi) ||
                    ((r_sbytes[j] == bi) && (IW'(j) <= i_cmd.idx)))) begin
                    r_tree[0][j] <= SUMW'(r_sbytes[j]);
                end else begin
                    r_tree[0][j] <= '0;
                end
            end else begin
                r_tree[0][j] <= '0;
            end
        end
        r_ti[0] <= i_cmd.idx;
        for (int l = 1; l <= LG; l++) begin
            for (int k = 0; k < P; k++) begin
                if (k < (P >> l)) begin
                    r_tree[l][k] <= r_tree[l-1][2*k] + r_tree[l-1][2*k+1];
                end else begin
                    r_tree[l][k] <= '0;
                end
            end
            r_ti[l] <= r_ti[l-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
        end else begin
            r_tv <= {r_tv[LG-1:0], i_cmd.issue && cand[i_cmd.idx]};
        end
    end

    // drop mask collects over the whole rank pass
    logic [SLOTS-1:0] r_drop;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= '0;
        end else if (i_cmd.load) begin
            r_drop <= '0;
        end else if (r_tv[LG] && (CMPW'(r_tree[LG][0]) > CMPW'(r_budget))) begin
            r_drop[r_ti[LG]] <= 1'b1;
        end
    end

    // eviction count, saturating
    logic [sbce_pkg::EVICT_W-1:0] r_evict;
    logic [sbce_pkg::EVICT_W-1:0] n_evict;
    always_comb begin
        int c;
        c = $countones(r_drop);
        n_evict = (c > sbce_pkg::EVICT_MAX) ? sbce_pkg::EVICT_W'(sbce_pkg::EVICT_MAX)
                                            : sbce_pkg::EVICT_W'(c);
    end

    // lowest matching slot and lowest free slot
    logic          hit_f, free_f;
    logic [IW-1:0] hit_i, free_i;
    always_comb begin
        hit_f  = 1'b0;
        hit_i  = '0;
        free_f = 1'b0;
        free_i = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (r_valid[j] && (r_skey[j] == r_key)) begin
                hit_f = 1'b1;
                hit_i = IW'(j);
            end
            if (!r_valid[j]) begin
                free_f = 1'b1;
                free_i = IW'(j);
            end
        end
    end

    logic do_insert;
    assign do_insert = i_cmd.lookup && !o_sts.probe && !hit_f && r_ok && free_f;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.apply) begin
            r_valid <= r_valid & ~r_drop;
        end else if (do_insert) begin
            r_valid[free_i] <= 1'b1;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            r_skey[free_i]   <= r_key;
            r_sbytes[free_i] <= r_bytes;
            r_sw[free_i]     <= r_w;
            r_sh[free_i]     <= r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_evict <= '0;
        end else if (i_cmd.apply) begin
            r_evict <= n_evict;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            o_was_present   <= hit_f;
            o_available     <= 1'b0;
            o_out_width_px  <= '0;
            o_out_height_px <= '0;
            o_evicted_count <= '0;
            o_table_full    <= 1'b0;
            if (!o_sts.probe) begin
                o_evicted_count <= r_evict;
                if (hit_f) begin
                    o_available     <= 1'b1;
                    o_out_width_px  <= r_sw[hit_i];
                    o_out_height_px <= r_sh[hit_i];
                end else if (r_ok) begin
                    if (free_f) begin
                        o_available     <= 1'b1;
                        o_out_width_px  <= r_w;
                        o_out_height_px <= r_h;
                    end else begin
                        o_table_full <= 1'b1;
                    end
                end
            end
        end
    end

    // dropped slots are gone after the apply step
    a_apply_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |=> ((r_valid & $past(r_drop)) == '0))
        else $error("dropped slot still valid after apply");

    // a full-table flag means every slot really is valid
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |=> (!o_table_full || (&r_valid)))
        else $error("table_full with a free slot");

    // never held and full at once
    a_full_not_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |=> !(o_table_full && o_available))
        else $error("table_full and available both set");

endmodule

`default_nettype wire

>>> rtl/sbce_ctrl.sv
// ----------------------------------------------------------------------------
// sbce_ctrl
// Sequencer: item capture, rank pass over all slots, apply, lookup/result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbce_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output sbce_pkg::t_cmd       o_cmd,
    input  wire sbce_pkg::t_sts  i_sts
);

    localparam int SLOTS = sbce_pkg::SLOTS;
    localparam int LG    = sbce_pkg::LG;
    localparam int CW    = sbce_pkg::CW;
    localparam int IW    = sbce_pkg::IW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVICT = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_LOOK  = 2'd3;

    localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS + LG);

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovld, n_ovld;
    logic          out_free;

    assign out_free    = !r_ovld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_ovld       = r_ovld && !i_out_ready;
        o_cmd        = '0;
        o_cmd.idx    = r_cnt[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_EVICT;
                end
            end
            S_EVICT: begin
                if (i_sts.probe) begin
                    n_state = S_LOOK;
                end else begin
                    o_cmd.issue = (r_cnt < CW'(SLOTS));
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_LOOK;
            end
            S_LOOK: begin
                if (out_free) begin
                    o_cmd.lookup = 1'b1;
                    n_ovld       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    // counter never runs past the tree drain
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |-> (r_cnt <= CNT_LAST))
        else $error("rank counter overran");

    // an accepted item always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_EVICT))
        else $error("accepted item not started");

    // lookup waits while the previous result is still held
    a_look_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && r_ovld && !i_out_ready) |=> (r_state == S_LOOK))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

>>> rtl/size_budget_cache_evictor_top.sv
// ----------------------------------------------------------------------------
// size_budget_cache_evictor_top
// Keyed table of sized entries kept under a byte budget.
// ----------------------------------------------------------------------------
// A request passes through capture, the rank pass, apply and lookup; a probe goes
// from capture straight to lookup. The rank pass issues one slot per cycle into a
// registered prefix-sum adder tree of log2(SLOTS) levels and then waits for the
// tree to drain. An apply step and a lookup step follow. One item is in work at a
// time. A finished result waits in the output register while the next item is
// already taken. The budget can be written only while the block is idle, so
// o_cfg_ready follows s_axis_tready.
`default_nettype none

module size_budget_cache_evictor_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration: budget_bytes
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [39:0]  i_cfg_data,
    // input items
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,  // key_tag, entry_bytes, width_px, height_px, load_ok
    input  wire logic         s_axis_tuser,  // command
    // result items
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [39:0]       m_axis_tdata   // was_present, available, out_width_px,
                                             // out_height_px, evicted_count, table_full
);

    sbce_pkg::t_cmd cmd;
    sbce_pkg::t_sts sts;

    logic                           was_present, available, table_full;
    logic [sbce_pkg::PX_W-1:0]      ow, oh;
    logic [sbce_pkg::EVICT_W-1:0]   evicted;

    // budget only taken while no item is in work
    assign o_cfg_ready = s_axis_tready;

    sbce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sbce_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_command       (s_axis_tuser),
        .i_key_tag       (s_axis_tdata[31:0]),
        .i_entry_bytes   (s_axis_tdata[67:32]),
        .i_width_px      (s_axis_tdata[81:68]),
        .i_height_px     (s_axis_tdata[95:82]),
        .i_load_ok       (s_axis_tdata[96]),
        .o_was_present   (was_present),
        .o_available     (available),
        .o_out_width_px  (ow),
        .o_out_height_px (oh),
        .o_evicted_count (evicted),
        .o_table_full    (table_full)
    );

    // result packing, lowest field first
    assign m_axis_tdata = {4'b0, table_full, evicted, oh, ow, available, was_present};

endmodule

`default_nettype wire
